// ----- src/ebd_pkg.sv -----
package ebd_pkg;

  localparam int LEVEL_W     = 15;
  localparam int INSTANT_W   = 16;
  localparam int THRESH_W    = 10;
  localparam int DECAY_W     = 16;
  localparam int BEAT_W      = 17;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [BEAT_W-1:0]   BEAT_ONE      = 17'h10000;
  localparam logic [THRESH_W-1:0] THRESH_RESET  = 10'd384;
  localparam logic [DECAY_W-1:0]  DECAY_RESET   = 16'd62259;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DECAY     = 8'd1;

  typedef struct packed {
    logic [THRESH_W-1:0] threshold_q8;
    logic [DECAY_W-1:0]  decay_q16;
  } cfg_t;

endpackage

// ----- src/ebd_cfg.sv -----
module ebd_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ebd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ebd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output ebd_pkg::cfg_t                    cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_q8 <= ebd_pkg::THRESH_RESET;
      cfg.decay_q16    <= ebd_pkg::DECAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ebd_pkg::REG_THRESHOLD: cfg.threshold_q8 <= cfg_data[ebd_pkg::THRESH_W-1:0];
        ebd_pkg::REG_DECAY:     cfg.decay_q16    <= cfg_data[ebd_pkg::DECAY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- src/ebd_history.sv -----
module ebd_history #(
  parameter int HISTORY_LEN = 43,
  parameter int SUM_W       = 22
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [ebd_pkg::INSTANT_W-1:0]  instant,
  output logic [SUM_W-1:0]               sum_next
);

  localparam int PTR_W = $clog2(HISTORY_LEN);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_LEN - 1);

  logic [ebd_pkg::INSTANT_W-1:0] mem [HISTORY_LEN];
  logic [PTR_W-1:0]              ptr;
  logic [PTR_W-1:0]              ptr_next;
  logic [PTR_W-1:0]              rd_addr;
  logic                          wrapped;
  logic                          wrapped_next;
  logic [ebd_pkg::INSTANT_W-1:0] old_raw;
  logic                          old_ok;
  logic [ebd_pkg::INSTANT_W-1:0] old_entry;
  logic [SUM_W-1:0]              sum;

  assign ptr_next     = (ptr == PTR_LAST) ? '0 : ptr + PTR_W'(1);
  assign wrapped_next = wrapped || (ptr == PTR_LAST);
  // entries are written in order, so an entry is live once the pointer has wrapped
  assign rd_addr      = step ? ptr_next : ptr;
  assign old_entry    = old_ok ? old_raw : '0;
  assign sum_next     = sum - SUM_W'(old_entry) + SUM_W'(instant);

  always_ff @(posedge clk) begin
    if (step) begin
      mem[ptr] <= instant;
    end
    old_raw <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr     <= '0;
      wrapped <= 1'b0;
      old_ok  <= 1'b0;
      sum     <= '0;
    end else begin
      old_ok <= step ? wrapped_next : wrapped;
      if (step) begin
        ptr     <= ptr_next;
        wrapped <= wrapped_next;
        sum     <= sum_next;
      end
    end
  end

endmodule

// ----- src/ebd_beat.sv -----
module ebd_beat #(
  parameter int HISTORY_LEN = 43,
  parameter int SUM_W       = 22
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  ebd_pkg::cfg_t                  cfg,
  input  logic [ebd_pkg::INSTANT_W-1:0]  instant,
  input  logic [SUM_W-1:0]               sum_next,
  output logic                           onset,
  output logic [ebd_pkg::BEAT_W-1:0]     level_next
);

  localparam int LHS_W = ebd_pkg::INSTANT_W + 9 + $clog2(HISTORY_LEN + 1);
  localparam int RHS_W = SUM_W + ebd_pkg::THRESH_W;
  localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam logic [CMP_W-1:0] SCALE = CMP_W'(HISTORY_LEN * 256);

  localparam int PI_W = ebd_pkg::BEAT_W + ebd_pkg::DECAY_W;
  localparam int PE_W = ebd_pkg::INSTANT_W + ebd_pkg::DECAY_W;

  logic [ebd_pkg::INSTANT_W-1:0] last_energy;
  logic [ebd_pkg::BEAT_W-1:0]    intensity;
  logic [CMP_W-1:0]              lhs;
  logic [CMP_W-1:0]              rhs;
  logic [PI_W-1:0]               prod_i;
  logic [PE_W-1:0]               prod_e;
  logic [ebd_pkg::INSTANT_W-1:0] last_next;

  assign lhs = CMP_W'(instant) * SCALE;
  assign rhs = CMP_W'(cfg.threshold_q8) * CMP_W'(sum_next);
  assign onset = (lhs > rhs) && (instant > last_energy);

  assign prod_i = PI_W'(intensity) * PI_W'(cfg.decay_q16);
  assign prod_e = PE_W'(last_energy) * PE_W'(cfg.decay_q16);

  // decayed intensity stays below 1.0, so only the beat value reaches 1.0
  assign level_next = onset ? ebd_pkg::BEAT_ONE : prod_i[PI_W-1 -: ebd_pkg::BEAT_W];
  assign last_next  = onset ? instant : prod_e[PE_W-1 -: ebd_pkg::INSTANT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      last_energy <= '0;
      intensity   <= '0;
    end else if (step) begin
      last_energy <= last_next;
      intensity   <= level_next;
    end
  end

endmodule

// ----- src/energy_beat_detector.sv -----
// channel | direction | handshake             | payload
// in      | to block  | in_valid / in_stall   | sub_bass_level, bass_level
// out     | from block| out_valid / out_stall | beat_level, beat_onset
// cfg     | to block  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item per cycle sustained while out is not stalled; each item passes the input register, then the result register
// the history memory entry for the next item is read one item ahead through its registered port
// reset clears control state at once; history entries read as zero until the pointer wraps
// while out is stalled one more item is held in the input register, then in_stall rises
module energy_beat_detector #(
  parameter int HISTORY_LEN = 43
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ebd_pkg::LEVEL_W-1:0]      sub_bass_level,
  input  logic [ebd_pkg::LEVEL_W-1:0]      bass_level,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ebd_pkg::BEAT_W-1:0]       beat_level,
  output logic                             beat_onset,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ebd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ebd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SUM_W = $clog2(HISTORY_LEN * 65535 + 1);

  ebd_pkg::cfg_t                 cfg;
  logic                          s1_valid;
  logic [ebd_pkg::LEVEL_W-1:0]   s1_sub;
  logic [ebd_pkg::LEVEL_W-1:0]   s1_bass;
  logic                          step;
  logic                          in_take;
  logic [ebd_pkg::INSTANT_W-1:0] instant;
  logic [SUM_W-1:0]              sum_next;
  logic                          onset;
  logic [ebd_pkg::BEAT_W-1:0]    level_next;

  assign step     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !step;
  assign in_take  = in_valid && !in_stall;
  assign instant  = ebd_pkg::INSTANT_W'(s1_sub) + ebd_pkg::INSTANT_W'(s1_bass);

  ebd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ebd_history #(
    .HISTORY_LEN (HISTORY_LEN),
    .SUM_W       (SUM_W)
  ) u_history (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .instant  (instant),
    .sum_next (sum_next)
  );

  ebd_beat #(
    .HISTORY_LEN (HISTORY_LEN),
    .SUM_W       (SUM_W)
  ) u_beat (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .cfg        (cfg),
    .instant    (instant),
    .sum_next   (sum_next),
    .onset      (onset),
    .level_next (level_next)
  );

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sub  <= sub_bass_level;
      s1_bass <= bass_level;
    end
    if (step) begin
      beat_level <= level_next;
      beat_onset <= onset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (step) begin
        s1_valid <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_onset_full_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && beat_onset) |-> (beat_level == ebd_pkg::BEAT_ONE))
    else $error("beat onset without full beat level");

  a_level_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (beat_level <= ebd_pkg::BEAT_ONE))
    else $error("beat level above 1.0");

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && out_stall) |-> in_stall)
    else $error("input taken while both stages are held");

  a_no_result_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");

endmodule

// ----- verif/tb_energy_beat_detector.sv -----
module tb_energy_beat_detector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_DEPTH = 43;
  localparam int LEVEL_ONE  = 16384;
  localparam int LEVEL_MAX  = 2 ** ebd_pkg::LEVEL_W - 1;
  localparam int HOLD_CYCLES = 80;
  localparam logic [ebd_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 8'hA5;

  typedef struct packed {
    logic [ebd_pkg::BEAT_W-1:0] level;
    logic                       onset;
  } beat_result_t;

  class beat_scoreboard;
    logic [ebd_pkg::INSTANT_W-1:0] energy_hist [HIST_DEPTH];
    int                            slot;
    logic [31:0]                   energy_total;
    logic [ebd_pkg::INSTANT_W-1:0] peak_energy;
    logic [ebd_pkg::BEAT_W-1:0]    intensity;
    logic [ebd_pkg::THRESH_W-1:0]  threshold;
    logic [ebd_pkg::DECAY_W-1:0]   decay;
    beat_result_t                  pending_beats [$];
    int                            errors;

    function new();
      foreach (energy_hist[i]) energy_hist[i] = '0;
      slot         = 0;
      energy_total = '0;
      peak_energy  = '0;
      intensity    = '0;
      threshold    = ebd_pkg::THRESH_RESET;
      decay        = ebd_pkg::DECAY_RESET;
      errors       = 0;
    endfunction

    function void write_register(logic [ebd_pkg::CFG_INDEX_W-1:0] idx,
                                 logic [ebd_pkg::CFG_DATA_W-1:0] data);
      if (idx == ebd_pkg::REG_THRESHOLD) begin
        threshold = data[ebd_pkg::THRESH_W-1:0];
      end else if (idx == ebd_pkg::REG_DECAY) begin
        decay = data[ebd_pkg::DECAY_W-1:0];
      end
    endfunction

    function void take_frame(logic [ebd_pkg::LEVEL_W-1:0] sub, logic [ebd_pkg::LEVEL_W-1:0] bass);
      logic [ebd_pkg::INSTANT_W-1:0] instant;
      logic [63:0]                   lhs;
      logic [63:0]                   rhs;
      logic [63:0]                   prod;
      beat_result_t                  res;
      instant = {1'b0, sub} + {1'b0, bass};
      energy_total = energy_total - 32'(energy_hist[slot]) + 32'(instant);
      energy_hist[slot] = instant;
      slot = (slot == HIST_DEPTH - 1) ? 0 : slot + 1;
      lhs = 64'(instant) * 64'(HIST_DEPTH) * 64'd256;
      rhs = 64'(threshold) * 64'(energy_total);
      res.onset = (lhs > rhs) && (instant > peak_energy);
      if (res.onset) begin
        intensity   = ebd_pkg::BEAT_ONE;
        peak_energy = instant;
      end else begin
        prod        = (64'(intensity) * 64'(decay)) >> 16;
        intensity   = prod[ebd_pkg::BEAT_W-1:0];
        prod        = (64'(peak_energy) * 64'(decay)) >> 16;
        peak_energy = prod[ebd_pkg::INSTANT_W-1:0];
      end
      if (intensity > ebd_pkg::BEAT_ONE) intensity = ebd_pkg::BEAT_ONE;
      res.level = intensity;
      pending_beats = {pending_beats, res};
    endfunction

    function void check_result(logic [ebd_pkg::BEAT_W-1:0] level, logic onset);
      beat_result_t want;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected result item level=%0d onset=%0d", $time, level, onset);
        errors++;
        return;
      end
      want = pending_beats.pop_front();
      if (level !== want.level) begin
        $display("%0t: beat_level expected %0d actual %0d", $time, want.level, level);
        errors++;
      end
      if (onset !== want.onset) begin
        $display("%0t: beat_onset expected %0d actual %0d", $time, want.onset, onset);
        errors++;
      end
    endfunction

    function int pending();
      return pending_beats.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic [ebd_pkg::LEVEL_W-1:0]     sub_bass_level;
  logic [ebd_pkg::LEVEL_W-1:0]     bass_level;
  logic                            out_valid;
  logic                            out_stall;
  logic [ebd_pkg::BEAT_W-1:0]      beat_level;
  logic                            beat_onset;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [ebd_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [ebd_pkg::CFG_DATA_W-1:0]  cfg_data;

  bit hold_request;
  bit hold_active;

  beat_scoreboard sb = new();

  energy_beat_detector #(.HISTORY_LEN(HIST_DEPTH)) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sub_bass_level (sub_bass_level),
    .bass_level     (bass_level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .beat_level     (beat_level),
    .beat_onset     (beat_onset),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // sample every handshake at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(beat_level, beat_onset);
      if (in_valid && !in_stall) sb.take_frame(sub_bass_level, bass_level);
      if (cfg_valid && cfg_ready) sb.write_register(cfg_index, cfg_data);
    end
  end

  // result side: random stalls, calm stretches, and one long hold-off on request
  initial begin
    int n;
    int calm_left;
    out_stall = 1'b0;
    calm_left = 0;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active  = 1'b1;
        n = HOLD_CYCLES;
      end else if (calm_left > 0) begin
        calm_left--;
        n = 0;
      end else if ($urandom_range(0, 19) == 0) begin
        calm_left = $urandom_range(10, 40);
        n = 0;
      end else begin
        n = $urandom_range(0, 14);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
        hold_active = 1'b0;
      end
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL energy_beat_detector");
    $finish;
  end

  task automatic send_frame(input logic [ebd_pkg::LEVEL_W-1:0] sub,
                            input logic [ebd_pkg::LEVEL_W-1:0] bass,
                            input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    sub_bass_level <= sub;
    bass_level     <= bass;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [ebd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [ebd_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // groups of frames: mostly quiet beds with periodic peaks, some noise,
  // and a few groups with levels above 1.0
  task automatic play_frames(input int count);
    int sent;
    int kind;
    int span;
    int period;
    int quiet;
    int peak;
    int peak_now;
    int gap_max;
    int gap;
    logic [ebd_pkg::LEVEL_W-1:0] sub;
    logic [ebd_pkg::LEVEL_W-1:0] bass;
    sent = 0;
    while (sent < count) begin
      kind    = $urandom_range(0, 9);
      span    = $urandom_range(6, 40);
      period  = $urandom_range(2, 12);
      quiet   = $urandom_range(0, 3000);
      peak    = $urandom_range(4000, LEVEL_ONE);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
      for (int k = 0; k < span && sent < count; k++) begin
        if (kind < 7) begin
          if (k % period == 0) begin
            peak_now = $urandom_range(peak / 2, peak);
            sub  = ebd_pkg::LEVEL_W'($urandom_range(0, peak_now));
            bass = ebd_pkg::LEVEL_W'(peak_now - int'(sub));
          end else begin
            sub  = ebd_pkg::LEVEL_W'($urandom_range(0, quiet));
            bass = ebd_pkg::LEVEL_W'($urandom_range(0, quiet));
          end
        end else if (kind < 9) begin
          sub  = ebd_pkg::LEVEL_W'($urandom_range(0, LEVEL_ONE));
          bass = ebd_pkg::LEVEL_W'($urandom_range(0, LEVEL_ONE));
        end else begin
          sub  = ebd_pkg::LEVEL_W'($urandom_range(0, LEVEL_MAX));
          bass = ebd_pkg::LEVEL_W'($urandom_range(0, LEVEL_MAX));
        end
        gap = (gap_max == 0 || hold_request || hold_active) ? 0 : $urandom_range(0, gap_max);
        send_frame(sub, bass, gap);
        sent++;
      end
    end
  endtask

  task automatic run_setting(input logic [ebd_pkg::CFG_DATA_W-1:0] thr,
                             input logic [ebd_pkg::CFG_DATA_W-1:0] dec,
                             input int count, input bit with_hold);
    drain();
    write_reg(ebd_pkg::REG_THRESHOLD, thr);
    write_reg(ebd_pkg::REG_DECAY, dec);
    if (with_hold) hold_request = 1'b1;
    play_frames(count);
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    sub_bass_level = '0;
    bass_level     = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    hold_request   = 1'b0;
    hold_active    = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    // extremes at the reset settings
    send_frame(15'd0, 15'd0, 0);
    send_frame(15'd16384, 15'd16384, 0);
    send_frame(15'd0, 15'd0, 3);
    send_frame(15'd16384, 15'd0, 0);
    send_frame(15'd0, 15'd16384, 1);
    // above 1.0, largest instant energy
    send_frame(15'h7FFF, 15'h7FFF, 0);
    send_frame(15'd1, 15'd0, 0);
    send_frame(15'd0, 15'd1, 2);
    send_frame(15'h2AAA, 15'h5555, 0);
    send_frame(15'h5555, 15'h2AAA, 0);
    send_frame(15'd100, 15'd100, 0);
    send_frame(15'd100, 15'd100, 5);
    send_frame(15'd8000, 15'd8000, 0);
    send_frame(15'd8000, 15'd8000, 0);
    send_frame(15'd12000, 15'd4000, 0);
    send_frame(15'd0, 15'd0, 0);

    // threshold zero by way of ignored upper bits, slowest decay, unmapped index
    drain();
    write_reg(REG_UNMAPPED, 16'h1234);
    run_setting(16'hFC00, 16'hFFFF, 190, 1'b0);
    // highest threshold, decay to zero at once
    run_setting(16'h03FF, 16'h0000, 190, 1'b0);
    run_setting(16'd256, 16'd32768, 190, 1'b0);
    // random settings, long output hold-off fills the block
    drain();
    write_reg(REG_UNMAPPED, 16'hFFFF);
    run_setting(ebd_pkg::CFG_DATA_W'($urandom_range(0, 65535)),
                ebd_pkg::CFG_DATA_W'($urandom_range(0, 65535)),
                190, 1'b1);
    run_setting(ebd_pkg::CFG_DATA_W'(ebd_pkg::THRESH_RESET), ebd_pkg::DECAY_RESET, 190, 1'b0);
    run_setting(16'd1, 16'd1, 200, 1'b0);

    drain();
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS energy_beat_detector");
    end else begin
      $display("FAIL energy_beat_detector");
    end
    $finish;
  end

endmodule

// ----- energy_beat_detector.f -----
src/ebd_pkg.sv
src/ebd_cfg.sv
src/ebd_history.sv
src/ebd_beat.sv
src/energy_beat_detector.sv
verif/tb_energy_beat_detector.sv
